>>> design/assert_macros.svh
// Assertion macros shared by the sequencer RTL.
// No dependencies; included by the modules that carry checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// expr must never be true at a clock edge out of reset
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(expr)) \
		else $error("assertion failed: forbidden condition seen");
// whenever ante holds, cons holds in the same cycle
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed: implication broken");
`else
`define ASSERT_NEVER(lbl, clk, rst_n, expr)
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`endif
`endif

>>> design/lcdnb_pkg.sv
// Package for the character LCD nibble bus sequencer.
// Payload structs, command and register codes, job type. No dependencies.
`timescale 1ns / 1ps
package lcdnb_pkg;

	localparam logic [2:0] CMD_WRITE_DATA = 3'd0;
	localparam logic [2:0] CMD_WRITE_CTRL = 3'd1;
	localparam logic [2:0] CMD_RAW_NIBBLE = 3'd2;
	localparam logic [2:0] CMD_SET_POS    = 3'd3;
	localparam logic [2:0] CMD_READ_REPLY = 3'd4;

	localparam logic [2:0] REG_POLL_LIMIT = 3'd0;
	localparam logic [2:0] REG_ROW0_START = 3'd1;
	localparam logic [2:0] REG_ROW1_START = 3'd2;
	localparam logic [2:0] REG_ROW2_START = 3'd3;
	localparam logic [2:0] REG_ROW3_START = 3'd4;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [15:0] POLL_LIMIT_RST = 16'd100;
	localparam logic [7:0]  ROW0_RST = 8'd128;
	localparam logic [7:0]  ROW1_RST = 8'd192;
	localparam logic [7:0]  ROW2_RST = 8'd148;
	localparam logic [7:0]  ROW3_RST = 8'd212;

	// busy flag is DB7, bit 3 of the high nibble read back
	localparam int BUSY_BIT = 3;

	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

	typedef struct packed {
		logic [2:0] cmd;
		logic [7:0] data_byte;
		logic [2:0] row;
		logic [7:0] column;
		logic [3:0] read_nibble;
	} lcdnb_cmd_t;

	typedef struct packed {
		logic       reg_select;
		logic       read_not_write;
		logic [3:0] bus_nibble;
		logic       wants_reply;
		logic       timed_out;
		logic       last;
	} lcdnb_strobe_t;

	typedef enum logic [1:0] {
		JOB_ROUND,
		JOB_WRITE,
		JOB_NIBBLE
	} lcdnb_job_kind_t;

	typedef struct packed {
		lcdnb_job_kind_t kind;
		logic [7:0]      byte_val;
		logic            rs;
		logic            tmo;
	} lcdnb_job_t;

endpackage

>>> design/lcdnb_front.sv
// Front end: config registers, command classification and poll bookkeeping.
// Depends on lcdnb_pkg; pushes jobs into lcdnb_queue.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module lcdnb_front (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [lcdnb_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [lcdnb_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                             accept,
	input  lcdnb_pkg::lcdnb_cmd_t            cmd,
	output logic                             push,
	output lcdnb_pkg::lcdnb_job_t            job
);
	import lcdnb_pkg::*;

	logic [15:0] poll_limit_q;
	logic [7:0]  row_start_q [4];
	logic [7:0]  pending_byte_q;
	logic        pending_is_data_q;
	logic        awaiting_q;
	logic [15:0] rounds_left_q;

	logic [7:0]  pending_byte_d;
	logic        pending_is_data_d;
	logic        awaiting_d;
	logic [15:0] rounds_left_d;
	logic [15:0] rounds_dec;
	logic [15:0] limit_eff;
	logic        busy;
	logic        start;
	logic [7:0]  start_byte;
	logic        start_data;

	assign rounds_dec = rounds_left_q - 16'd1;
	assign limit_eff  = (poll_limit_q == '0) ? 16'd1 : poll_limit_q;
	assign busy       = cmd.read_nibble[BUSY_BIT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			poll_limit_q   <= POLL_LIMIT_RST;
			row_start_q[0] <= ROW0_RST;
			row_start_q[1] <= ROW1_RST;
			row_start_q[2] <= ROW2_RST;
			row_start_q[3] <= ROW3_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_POLL_LIMIT: poll_limit_q   <= cfg_data;
				REG_ROW0_START: row_start_q[0] <= cfg_data[7:0];
				REG_ROW1_START: row_start_q[1] <= cfg_data[7:0];
				REG_ROW2_START: row_start_q[2] <= cfg_data[7:0];
				REG_ROW3_START: row_start_q[3] <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		push              = 1'b0;
		job               = '{kind: JOB_NIBBLE, byte_val: '0, rs: 1'b0, tmo: 1'b0};
		pending_byte_d    = pending_byte_q;
		pending_is_data_d = pending_is_data_q;
		awaiting_d        = awaiting_q;
		rounds_left_d     = rounds_left_q;
		start             = 1'b0;
		start_byte        = cmd.data_byte;
		start_data        = 1'b0;
		if (accept) begin
			if (cmd.cmd == CMD_READ_REPLY) begin
				if (awaiting_q) begin
					rounds_left_d = rounds_dec;
					push          = 1'b1;
					if (busy && rounds_dec != '0) begin
						job.kind = JOB_ROUND;
					end else begin
						awaiting_d   = 1'b0;
						job.kind     = JOB_WRITE;
						job.byte_val = pending_byte_q;
						job.rs       = pending_is_data_q;
						job.tmo      = busy;
					end
				end
			end else if (!awaiting_q) begin
				case (cmd.cmd)
					CMD_WRITE_DATA: begin
						start      = 1'b1;
						start_data = 1'b1;
					end
					CMD_WRITE_CTRL: start = 1'b1;
					CMD_RAW_NIBBLE: begin
						push         = 1'b1;
						job.kind     = JOB_NIBBLE;
						job.byte_val = {4'd0, cmd.data_byte[3:0]};
					end
					CMD_SET_POS: begin
						if (!cmd.row[2]) begin
							start      = 1'b1;
							start_byte = row_start_q[cmd.row[1:0]] + cmd.column;
						end
					end
					default: ;
				endcase
				if (start) begin
					push              = 1'b1;
					job.kind          = JOB_ROUND;
					pending_byte_d    = start_byte;
					pending_is_data_d = start_data;
					awaiting_d        = 1'b1;
					rounds_left_d     = limit_eff;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_byte_q    <= '0;
			pending_is_data_q <= 1'b0;
			awaiting_q        <= 1'b0;
			rounds_left_q     <= '0;
		end else begin
			pending_byte_q    <= pending_byte_d;
			pending_is_data_q <= pending_is_data_d;
			awaiting_q        <= awaiting_d;
			rounds_left_q     <= rounds_left_d;
		end
	end

	// a running poll always has at least one round left to count down
	`ASSERT_IMPL(a_rounds_live, clk, arst_n, awaiting_q, rounds_left_q != '0)
	// a push only comes from an accepted command
	`ASSERT_IMPL(a_push_on_accept, clk, arst_n, push, accept)
	// a poll that is still running never sends its pending byte
	`ASSERT_NEVER(a_no_write_mid_poll, clk, arst_n,
		push && job.kind == JOB_WRITE && awaiting_d)

endmodule

>>> design/lcdnb_queue.sv
// Short job queue between front and back ends.
// Depends on lcdnb_pkg for the job type and depth.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module lcdnb_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  lcdnb_pkg::lcdnb_job_t push_job,
	output logic                  full,
	input  logic                  pop,
	output logic                  head_valid,
	output lcdnb_pkg::lcdnb_job_t head_job
);
	import lcdnb_pkg::*;

	lcdnb_job_t             slot_q [QUEUE_DEPTH];
	logic [QUEUE_PTR_W-1:0] wr_ptr_q;
	logic [QUEUE_PTR_W-1:0] rd_ptr_q;
	logic [QUEUE_PTR_W:0]   count_q;
	logic                   do_pop;

	assign full       = (count_q == (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_job   = slot_q[rd_ptr_q];
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (push) slot_q[wr_ptr_q] <= push_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)   wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			case ({push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: ;
			endcase
		end
	end

	`ASSERT_NEVER(a_no_overflow, clk, arst_n, push && full)
	`ASSERT_NEVER(a_count_range, clk, arst_n,
		count_q > (QUEUE_PTR_W+1)'(QUEUE_DEPTH))

endmodule

>>> design/lcdnb_back.sv
// Back end: expands queued jobs into bus strobes, one per cycle while strobe_ready keeps up.
// Depends on lcdnb_pkg; pops lcdnb_queue, drives the strobe output register.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module lcdnb_back (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     head_valid,
	input  lcdnb_pkg::lcdnb_job_t    head_job,
	output logic                     pop,
	output logic                     strobe_valid,
	input  logic                     strobe_ready,
	output lcdnb_pkg::lcdnb_strobe_t strobe
);
	import lcdnb_pkg::*;

	logic          second_q;
	logic          out_valid_q;
	lcdnb_strobe_t out_q;
	logic          load;
	logic          final_strobe;
	lcdnb_strobe_t next_s;

	assign load         = head_valid && (!out_valid_q || strobe_ready);
	assign final_strobe = second_q || head_job.kind == JOB_NIBBLE;
	assign pop          = load && final_strobe;
	assign strobe_valid = out_valid_q;
	assign strobe       = out_q;

	always_comb begin
		next_s = '0;
		case (head_job.kind)
			JOB_ROUND: begin
				next_s.read_not_write = 1'b1;
				next_s.wants_reply    = !second_q;
			end
			JOB_WRITE: begin
				next_s.reg_select = head_job.rs;
				next_s.bus_nibble = second_q ? head_job.byte_val[3:0]
				                             : head_job.byte_val[7:4];
				next_s.timed_out  = head_job.tmo;
				next_s.last       = second_q;
			end
			JOB_NIBBLE: begin
				next_s.bus_nibble = head_job.byte_val[3:0];
				next_s.last       = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (load) out_q <= next_s;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			second_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (load)              out_valid_q <= 1'b1;
			else if (strobe_ready) out_valid_q <= 1'b0;
			if (load)              second_q    <= !final_strobe;
		end
	end

	// halfway through a two-strobe job, that job stays at the queue head
	`ASSERT_IMPL(a_second_has_job, clk, arst_n, second_q,
		head_valid && head_job.kind != JOB_NIBBLE)
	// a poll read strobe never drives data and never ends a command
	`ASSERT_IMPL(a_read_shape, clk, arst_n, out_valid_q && out_q.read_not_write,
		out_q.bus_nibble == '0 && !out_q.last && !out_q.timed_out)

endmodule

>>> design/char_lcd_nibble_bus_sequencer.sv
// Character LCD sequencer for a 4-bit bus: top level, ties front, queue, back.
// Depends on lcdnb_pkg, lcdnb_front, lcdnb_queue, lcdnb_back.
`timescale 1ns / 1ps
// Each accepted command turns into zero, one or two bus strobes, one strobe
// per result transfer. Write data, write control and set position start a
// busy poll: a round of two read strobes (RS=0, R/W=1), the first flagged
// wants_reply. The nibble sampled there comes back as a read-reply command;
// busy clear, or the poll_limit rounds used up (timed_out set), sends the
// pending byte as two write strobes, high nibble first. Raw nibble is one
// write strobe with no poll. Commands other than replies that arrive during
// a poll are dropped, and so are replies with no poll running. Rate: the
// front end takes one command transfer per cycle while the four-entry job
// queue has room; the back end loads one strobe per cycle into its output
// register when it is empty or being taken, so a polled command or reply
// costs two strobes and a raw nibble one. Config writes take effect on the
// next cycle and should only be made with no command in flight.
module char_lcd_nibble_bus_sequencer (
	input  logic                             clk,
	input  logic                             arst_n,
	// configuration write port
	input  logic                             cfg_we,
	input  logic [lcdnb_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [lcdnb_pkg::CFG_DATA_W-1:0] cfg_data,
	// command channel
	input  logic                             cmd_valid,
	output logic                             cmd_ready,
	input  lcdnb_pkg::lcdnb_cmd_t            cmd,
	// strobe channel
	output logic                             strobe_valid,
	input  logic                             strobe_ready,
	output lcdnb_pkg::lcdnb_strobe_t         strobe
);
	import lcdnb_pkg::*;

	logic       accept;
	logic       push;
	lcdnb_job_t push_job;
	logic       full;
	logic       pop;
	logic       head_valid;
	lcdnb_job_t head_job;

	// every command may push one job, so room in the queue is all we need
	assign cmd_ready = !full;
	assign accept    = cmd_valid && cmd_ready;

	lcdnb_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.accept    (accept),
		.cmd       (cmd),
		.push      (push),
		.job       (push_job)
	);

	lcdnb_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_job   (push_job),
		.full       (full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_job   (head_job)
	);

	lcdnb_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_valid   (head_valid),
		.head_job     (head_job),
		.pop          (pop),
		.strobe_valid (strobe_valid),
		.strobe_ready (strobe_ready),
		.strobe       (strobe)
	);

endmodule

>>> tb/tb.sv
// Self-checking testbench for the character LCD nibble bus sequencer.
// Depends on lcdnb_pkg and char_lcd_nibble_bus_sequencer; needs no files or arguments.
`timescale 1ns / 1ps
module tb;
	import lcdnb_pkg::*;

	localparam int RANDOM_ITEMS  = 40;	// strobe-producing commands in the random phase
	localparam int BURST_ITEMS   = 20;	// commands in the no-idle stretch
	localparam int RECONFIG_SPAN = 25;	// random commands between register changes
	localparam int SETTLE_CYCLES = 24;	// queue depth plus front and back end, with margin
	localparam int CYCLE_LIMIT   = 200000;
	localparam int IDLE_PCT      = 8;
	localparam int MAX_REPORTS   = 10;
	localparam int ROW_COUNT     = 4;

	// codes with no meaning in the block, used to check that they are ignored
	localparam logic [2:0] CMD_UNUSED_FIRST = 3'd5;
	localparam logic [2:0] REG_UNUSED_FIRST = 3'd5;
	localparam logic [2:0] CODE_MAX         = 3'd7;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  cmd_valid;
	logic                  cmd_ready;
	lcdnb_cmd_t            cmd;
	logic                  strobe_valid;
	logic                  strobe_ready = 1'b0;
	lcdnb_strobe_t         strobe;

	char_lcd_nibble_bus_sequencer dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.cmd_valid   (cmd_valid),
		.cmd_ready   (cmd_ready),
		.cmd         (cmd),
		.strobe_valid(strobe_valid),
		.strobe_ready(strobe_ready),
		.strobe      (strobe)
	);

	// 2 ns period
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Shadow of the sequencer: register copies and poll state, updated in
	// transfer order so that it always matches what the block has taken.
	logic [15:0]   lim_shadow;
	logic [7:0]    row_base [ROW_COUNT];
	logic [7:0]    held_byte;
	logic          held_is_data;
	logic          polling;
	logic [15:0]   rounds_left;
	lcdnb_strobe_t strobe_exp_q [$];

	int  errors        = 0;
	int  cmds_taken    = 0;
	int  productive    = 0;	// transfers that gave at least one strobe
	int  strobes_seen  = 0;
	int  timeouts_seen = 0;
	int  reg_writes    = 0;
	int  cycle_count   = 0;
	bit  no_idle       = 1'b0;

	function automatic void flag_error(input string msg);
		errors++;
		if (errors <= MAX_REPORTS)
			$display("%0t ERROR %s", $time, msg);
	endfunction

	function automatic string strobe_text(input lcdnb_strobe_t s);
		return $sformatf("rs=%0b rnw=%0b nib=%h reply=%0b tmo=%0b last=%0b",
			s.reg_select, s.read_not_write, s.bus_nibble, s.wants_reply,
			s.timed_out, s.last);
	endfunction

	function automatic lcdnb_strobe_t make_strobe(input logic rs, input logic rnw,
			input logic [3:0] nib, input logic reply, input logic tmo, input logic fin);
		lcdnb_strobe_t s;
		s.reg_select     = rs;
		s.read_not_write = rnw;
		s.bus_nibble     = nib;
		s.wants_reply    = reply;
		s.timed_out      = tmo;
		s.last           = fin;
		return s;
	endfunction

	// one busy-poll round: two reads, only the first asks for the nibble back
	function automatic void queue_poll_round();
		strobe_exp_q.push_back(make_strobe(1'b0, 1'b1, 4'h0, 1'b1, 1'b0, 1'b0));
		strobe_exp_q.push_back(make_strobe(1'b0, 1'b1, 4'h0, 1'b0, 1'b0, 1'b0));
		polling = 1'b1;
	endfunction

	function automatic void open_poll(input logic [7:0] b, input logic is_data);
		held_byte    = b;
		held_is_data = is_data;
		// a zero limit still allows one round
		rounds_left  = (lim_shadow == 16'd0) ? 16'd1 : lim_shadow;
		queue_poll_round();
	endfunction

	// Expected strobes for one accepted command; returns how many it queued.
	function automatic int predict_strobes(input lcdnb_cmd_t c);
		int   n_before;
		logic busy;
		logic [7:0] addr;
		n_before = strobe_exp_q.size();
		if (c.cmd == CMD_READ_REPLY) begin
			// a reply with no poll running is ignored
			if (polling) begin
				busy        = c.read_nibble[BUSY_BIT];
				rounds_left = rounds_left - 16'd1;
				if (busy && rounds_left != 16'd0) begin
					queue_poll_round();
				end else begin
					// busy clear, or out of rounds: write anyway, high nibble first
					polling = 1'b0;
					strobe_exp_q.push_back(make_strobe(held_is_data, 1'b0,
						held_byte[7:4], 1'b0, busy, 1'b0));
					strobe_exp_q.push_back(make_strobe(held_is_data, 1'b0,
						held_byte[3:0], 1'b0, busy, 1'b1));
				end
			end
		end else if (!polling) begin
			// anything but a reply is dropped while a poll runs
			case (c.cmd)
				CMD_WRITE_DATA: open_poll(c.data_byte, 1'b1);
				CMD_WRITE_CTRL: open_poll(c.data_byte, 1'b0);
				CMD_RAW_NIBBLE: begin
					strobe_exp_q.push_back(make_strobe(1'b0, 1'b0, c.data_byte[3:0],
						1'b0, 1'b0, 1'b1));
				end
				CMD_SET_POS: begin
					// rows past the last do nothing; the sum wraps at 8 bits
					if (c.row < ROW_COUNT) begin
						addr = row_base[c.row[1:0]] + c.column;
						open_poll(addr, 1'b0);
					end
				end
				default: ;
			endcase
		end
		return strobe_exp_q.size() - n_before;
	endfunction

	// Strobe side: stalls about 8 percent of the time unless the burst test runs.
	always @(posedge clk)
		strobe_ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);

	// Every strobe transfer is checked against the oldest expectation.
	always @(posedge clk) begin : check_strobes
		lcdnb_strobe_t want;
		if (arst_n && strobe_valid && strobe_ready) begin
			strobes_seen++;
			if (strobe.timed_out && strobe.last)
				timeouts_seen++;
			if (strobe_exp_q.size() == 0) begin
				flag_error({"strobe with none expected: ", strobe_text(strobe)});
			end else begin
				want = strobe_exp_q.pop_front();
				if (strobe.reg_select !== want.reg_select
						|| strobe.read_not_write !== want.read_not_write
						|| strobe.bus_nibble !== want.bus_nibble
						|| strobe.wants_reply !== want.wants_reply
						|| strobe.timed_out !== want.timed_out
						|| strobe.last !== want.last)
					flag_error({"strobe mismatch: expected ", strobe_text(want),
						" got ", strobe_text(strobe)});
			end
		end
	end

	// Watchdog: a hang anywhere ends the run as a failure.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d strobes outstanding",
				cycle_count, strobe_exp_q.size());
			$display("status: fail");
			$finish;
		end
	end

	// Register write; legal only with the block idle, so the shadow follows at once.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		cfg_index <= idx;
		cfg_data  <= val;
		cfg_we    <= 1'b1;
		@(posedge clk);
		cfg_we    <= 1'b0;
		@(posedge clk);
		reg_writes++;
		case (idx)
			REG_POLL_LIMIT: lim_shadow  = val;
			REG_ROW0_START: row_base[0] = val[7:0];
			REG_ROW1_START: row_base[1] = val[7:0];
			REG_ROW2_START: row_base[2] = val[7:0];
			REG_ROW3_START: row_base[3] = val[7:0];
			default: ;
		endcase
	endtask

	// One command transfer. Valid is only lowered when a gap is taken, so it
	// never drops and rises in the same step.
	task automatic send_cmd(input lcdnb_cmd_t c);
		int gap;
		int n;
		gap = 0;
		if (!no_idle && $urandom_range(99) < IDLE_PCT)
			gap = $urandom_range(4, 1);
		if (gap > 0) begin
			cmd_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd       <= c;
		cmd_valid <= 1'b1;
		do @(posedge clk); while (!cmd_ready);
		cmds_taken++;
		n = predict_strobes(c);
		if (n > 0)
			productive++;
	endtask

	// random payload in every field, then the command code forced
	function automatic lcdnb_cmd_t rand_item(input logic [2:0] code);
		lcdnb_cmd_t c;
		c     = $bits(lcdnb_cmd_t)'($urandom);
		c.cmd = code;
		return c;
	endfunction

	// the display's answer to a poll round
	task automatic send_reply(input logic busy);
		lcdnb_cmd_t c;
		c = rand_item(CMD_READ_REPLY);
		c.read_nibble[BUSY_BIT] = busy;
		send_cmd(c);
	endtask

	task automatic send_byte(input logic [2:0] code, input logic [7:0] b);
		lcdnb_cmd_t c;
		c = rand_item(code);
		c.data_byte = b;
		send_cmd(c);
	endtask

	task automatic send_pos(input logic [2:0] r, input logic [7:0] col);
		lcdnb_cmd_t c;
		c = rand_item(CMD_SET_POS);
		c.row    = r;
		c.column = col;
		send_cmd(c);
	endtask

	// Close any open poll, hold the command side off until every expected
	// strobe is in, then give dropped commands time to leave the pipe.
	task automatic quiesce();
		while (polling)
			send_reply(1'b0);
		cmd_valid <= 1'b0;
		while (strobe_exp_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Mostly well-formed traffic: a poll gets replies, busy about 60% of the time.
	task automatic random_step();
		lcdnb_cmd_t c;
		int r;
		r = $urandom_range(99);
		if (polling) begin
			if (r < 85)
				send_reply($urandom_range(99) < 60);
			else
				send_cmd(rand_item(3'($urandom)));	// usually dropped
		end else if (r < 22) begin
			send_cmd(rand_item(CMD_WRITE_DATA));
		end else if (r < 40) begin
			send_cmd(rand_item(CMD_WRITE_CTRL));
		end else if (r < 62) begin
			c = rand_item(CMD_SET_POS);
			if ($urandom_range(99) < 80)
				c.row = 3'($urandom_range(ROW_COUNT - 1));
			send_cmd(c);
		end else if (r < 84) begin
			send_cmd(rand_item(CMD_RAW_NIBBLE));
		end else begin
			send_cmd(rand_item(3'($urandom)));
		end
	endtask

	// Reset register values: field extremes, every command, and the ignored cases.
	task automatic test_defaults();
		send_byte(CMD_WRITE_DATA, 8'h00);
		send_reply(1'b0);
		send_byte(CMD_WRITE_DATA, 8'hFF);
		send_reply(1'b1);
		send_reply(1'b0);
		send_byte(CMD_WRITE_CTRL, 8'hA5);
		send_reply(1'b0);
		send_pos(3'd0, 8'h00);
		send_reply(1'b0);
		send_pos(3'd3, 8'hFF);	// column overflow wraps
		send_reply(1'b0);
		send_pos(3'd7, 8'h09);	// row out of range
		send_byte(CMD_RAW_NIBBLE, 8'hF0);
		send_byte(CMD_RAW_NIBBLE, 8'h0F);
		send_reply(1'b0);	// reply with nothing polling
		for (int i = CMD_UNUSED_FIRST; i <= CODE_MAX; i++)
			send_cmd(rand_item(3'(i)));
		// commands that land during a poll are dropped
		send_byte(CMD_WRITE_DATA, 8'h3C);
		send_byte(CMD_WRITE_CTRL, 8'h01);
		send_pos(3'd1, 8'h00);
		send_byte(CMD_RAW_NIBBLE, 8'h07);
		send_reply(1'b0);
		quiesce();
	endtask

	// Poll limit at zero, one, a few and the maximum, with timeouts.
	task automatic test_poll_limit();
		write_reg(REG_POLL_LIMIT, 16'd1);
		send_byte(CMD_WRITE_DATA, 8'h5A);
		send_reply(1'b1);
		quiesce();
		write_reg(REG_POLL_LIMIT, 16'd0);	// behaves as one round
		send_byte(CMD_WRITE_CTRL, 8'h00);
		send_reply(1'b1);
		quiesce();
		write_reg(REG_POLL_LIMIT, 16'd3);
		send_pos(3'd2, 8'h05);
		repeat (3) send_reply(1'b1);
		quiesce();
		write_reg(REG_POLL_LIMIT, 16'hFFFF);
		send_byte(CMD_WRITE_DATA, 8'hC3);
		send_reply(1'b1);
		send_reply(1'b1);
		send_reply(1'b0);
		quiesce();
	endtask

	// Row start registers at their extremes, upper write bits ignored,
	// writes to unused indexes harmless.
	task automatic test_row_starts();
		write_reg(REG_ROW0_START, 16'hFF00);
		write_reg(REG_ROW1_START, 16'h00FF);
		write_reg(REG_ROW2_START, 16'h0000);
		write_reg(REG_ROW3_START, 16'hFFFF);
		send_pos(3'd0, 8'h00);
		send_reply(1'b0);
		send_pos(3'd1, 8'hFF);
		send_reply(1'b0);
		send_pos(3'd2, 8'hFF);
		send_reply(1'b0);
		send_pos(3'd3, 8'h01);
		send_reply(1'b0);
		quiesce();
		for (int i = REG_UNUSED_FIRST; i <= CODE_MAX; i++)
			write_reg(3'(i), 16'($urandom));
		send_pos(3'd1, 8'h10);
		send_reply(1'b0);
		quiesce();
	endtask

	// Random traffic with new register settings every so often.
	task automatic test_random();
		int goal;
		int next_cfg;
		int r;
		logic [15:0] lim;
		goal     = productive + RANDOM_ITEMS;
		next_cfg = productive;
		while (productive < goal) begin
			if (productive >= next_cfg) begin
				quiesce();
				r = $urandom_range(99);
				if (r < 10)
					lim = 16'd0;
				else if (r < 20)
					lim = 16'hFFFF;
				else if (r < 60)
					lim = 16'($urandom_range(4, 1));
				else
					lim = 16'($urandom_range(100, 1));
				write_reg(REG_POLL_LIMIT, lim);
				write_reg(REG_ROW0_START, 16'($urandom));
				write_reg(REG_ROW1_START, 16'($urandom));
				write_reg(REG_ROW2_START, 16'($urandom));
				write_reg(REG_ROW3_START, 16'($urandom));
				if ($urandom_range(3) == 0)
					write_reg(3'($urandom_range(CODE_MAX, REG_UNUSED_FIRST)), 16'($urandom));
				next_cfg = productive + RECONFIG_SPAN;
			end
			random_step();
		end
		quiesce();
	endtask

	// Back-to-back transfers on both sides with no idling at all.
	task automatic test_back_to_back();
		int goal;
		goal    = productive + BURST_ITEMS;
		no_idle = 1'b1;
		while (productive < goal)
			random_step();
		no_idle = 1'b0;
		quiesce();
	endtask

	initial begin
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		cmd_valid = 1'b0;
		cmd       = '0;
		// shadow starts from the reset values
		lim_shadow   = POLL_LIMIT_RST;
		row_base[0]  = ROW0_RST;
		row_base[1]  = ROW1_RST;
		row_base[2]  = ROW2_RST;
		row_base[3]  = ROW3_RST;
		held_byte    = '0;
		held_is_data = 1'b0;
		polling      = 1'b0;
		rounds_left  = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_defaults();
		test_poll_limit();
		test_row_starts();
		test_random();
		test_back_to_back();

		if (strobe_exp_q.size() != 0)
			flag_error($sformatf("%0d expected strobes never came", strobe_exp_q.size()));
		$display("ran %0d commands (%0d gave strobes), checked %0d strobes, %0d poll timeouts",
			cmds_taken, productive, strobes_seen, timeouts_seen);
		$display("%0d register writes over several limit and row-start settings, %0d errors",
			reg_writes, errors);
		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
